// File: hdl/efp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_pkg
// Shared types, register codes, reset values and the palette shade table
// for the escape-time fractal pixel block.
// ----------------------------------------------------------------------------
package efp_pkg;

  localparam int DEF_IMAGE_WIDTH    = 1024;
  localparam int DEF_IMAGE_HEIGHT   = 1024;
  localparam int DEF_PALETTE_LEVELS = 6;

  localparam int FRAC_BITS  = 27;
  localparam int NUM_DIGITS = 3;
  localparam int DIGIT_W    = 3;
  localparam int COORD_W    = 10;
  localparam int COUNT_W    = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam logic [63:0] FOUR_Q54 = 64'h0100_0000_0000_0000;

  localparam logic signed [31:0] RST_X_ORIGIN   = -32'sd402653184;
  localparam logic        [30:0] RST_X_STEP     = 31'd1006633;
  localparam logic signed [31:0] RST_Y_ORIGIN   = -32'sd402653184;
  localparam logic        [30:0] RST_Y_STEP     = 31'd1006633;
  localparam logic               RST_MODE_MANDEL = 1'b1;
  localparam logic signed [31:0] RST_JULIA_REAL = -32'sd67108864;
  localparam logic signed [31:0] RST_JULIA_IMAG = 32'sd80530637;
  localparam logic [COUNT_W-1:0] RST_ITER_LIMIT = 8'd216;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_X_STEP     = 3'd1,
    CFG_Y_ORIGIN   = 3'd2,
    CFG_Y_STEP     = 3'd3,
    CFG_MODE       = 3'd4,
    CFG_JULIA_REAL = 3'd5,
    CFG_JULIA_IMAG = 3'd6,
    CFG_ITER_LIMIT = 3'd7
  } cfg_index_e;

  typedef struct packed {
    logic signed [31:0]  x_origin;
    logic [30:0]         x_step;
    logic signed [31:0]  y_origin;
    logic [30:0]         y_step;
    logic                mode_mandelbrot;
    logic signed [31:0]  julia_real;
    logic signed [31:0]  julia_imag;
    logic [COUNT_W-1:0]  iteration_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_e;

  // 256 / divisor, with 256 held as 255
  function automatic logic [7:0] shade(input logic [DIGIT_W-1:0] divisor);
    logic [7:0] v;
    unique case (divisor)
      3'd1:    v = 8'd255;
      3'd2:    v = 8'd128;
      3'd3:    v = 8'd85;
      3'd4:    v = 8'd64;
      3'd5:    v = 8'd51;
      3'd6:    v = 8'd42;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/efp_digit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_digit_cell
// One base-L digit of the iteration count. Takes a carry from the lower
// neighbor and passes its own carry to the upper neighbor.
// ----------------------------------------------------------------------------
module efp_digit_cell import efp_pkg::*; #(
  parameter int PALETTE_LEVELS = DEF_PALETTE_LEVELS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clr_i,
  input  logic               carry_i,
  output logic               carry_o,
  output logic [DIGIT_W-1:0] digit_o
);

  localparam logic [DIGIT_W-1:0] DigitMax = DIGIT_W'(PALETTE_LEVELS - 1);

  logic [DIGIT_W-1:0] digit_q, digit_d;

  assign carry_o = carry_i && (digit_q == DigitMax);
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (clr_i) begin
      digit_d = '0;
    end else if (carry_i) begin
      digit_d = (digit_q == DigitMax) ? '0 : digit_q + DIGIT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// File: hdl/efp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efp_core
// Coordinate mapping, z = z*z + c iteration, digit-cell count chain,
// palette lookup and output word register.
// ----------------------------------------------------------------------------
module efp_core import efp_pkg::*; #(
  parameter int IMAGE_WIDTH    = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT   = DEF_IMAGE_HEIGHT,
  parameter int PALETTE_LEVELS = DEF_PALETTE_LEVELS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] pixel_column_i,
  input  logic [COORD_W-1:0] pixel_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [COUNT_W-1:0] iterations_o,
  output logic               escaped_o
);

  localparam int TABLE_SIZE = PALETTE_LEVELS * PALETTE_LEVELS * PALETTE_LEVELS;
  localparam logic [COUNT_W-1:0] TableSize = COUNT_W'(TABLE_SIZE);
  localparam logic [31:0] ColMax = 32'(IMAGE_WIDTH - 1);
  localparam logic [31:0] RowMax = 32'(IMAGE_HEIGHT - 1);
  localparam logic [DIGIT_W-1:0] Levels = DIGIT_W'(PALETTE_LEVELS);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [COORD_W-1:0] col_q, row_q;
  logic [40:0]        prod_x_q, prod_y_q;
  logic signed [31:0] zx_q, zy_q, cx_q, cy_q;
  logic signed [63:0] pxx_q, pyy_q, pxy_q;
  logic [COUNT_W-1:0] count_q;
  logic               esc_q;
  logic               out_valid_q;
  logic [7:0]         red_q, green_q, blue_q;
  logic [COUNT_W-1:0] iter_q;
  logic               escaped_q;

  logic               accept;
  logic               load_out;
  logic               digit_clr;
  logic               digit_inc;
  logic               stop;
  logic [COORD_W-1:0] col_clamped, row_clamped;
  logic [COUNT_W-1:0] limit;
  logic [63:0]        mag;
  logic signed [63:0] sq;
  logic signed [63:0] nx_wide, ny_wide;
  logic signed [63:0] px_wide, py_wide;
  logic               palette_on;

  logic [NUM_DIGITS:0]              carry;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit;

  assign carry[0] = digit_inc;

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_digit
    efp_digit_cell #(
      .PALETTE_LEVELS(PALETTE_LEVELS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (digit_clr),
      .carry_i(carry[i]),
      .carry_o(carry[i+1]),
      .digit_o(digit[i])
    );
  end

  assign col_clamped = (32'(pixel_column_i) > ColMax) ? COORD_W'(ColMax) : pixel_column_i;
  assign row_clamped = (32'(pixel_row_i) > RowMax) ? COORD_W'(RowMax) : pixel_row_i;
  assign limit = (cfg_i.iteration_limit > TableSize) ? TableSize : cfg_i.iteration_limit;

  assign px_wide = 64'(cfg_i.x_origin) + $signed({23'd0, prod_x_q});
  assign py_wide = 64'(cfg_i.y_origin) + $signed({23'd0, prod_y_q});

  assign mag     = $unsigned(pxx_q) + $unsigned(pyy_q);
  assign stop    = (mag >= FOUR_Q54) || (count_q >= limit);
  assign sq      = pxx_q - pyy_q;
  assign nx_wide = (sq >>> FRAC_BITS) + 64'(cx_q);
  assign ny_wide = (pxy_q >>> (FRAC_BITS - 1)) + 64'(cy_q);

  assign palette_on = esc_q && (count_q < TableSize);

  always_comb begin
    state_d   = state_q;
    accept    = 1'b0;
    load_out  = 1'b0;
    digit_clr = 1'b0;
    digit_inc = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        state_d = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        digit_clr = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (stop) begin
          state_d = ST_DONE;
        end else begin
          digit_inc = 1'b1;
          state_d   = ST_MUL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= col_clamped;
      row_q <= row_clamped;
    end
    if (state_q == ST_MAP_MUL) begin
      prod_x_q <= 41'(col_q) * 41'(cfg_i.x_step);
      prod_y_q <= 41'(row_q) * 41'(cfg_i.y_step);
    end
    if (state_q == ST_MAP_ADD) begin
      count_q <= '0;
      if (cfg_i.mode_mandelbrot) begin
        cx_q <= sat32(px_wide);
        cy_q <= sat32(py_wide);
        zx_q <= '0;
        zy_q <= '0;
      end else begin
        zx_q <= sat32(px_wide);
        zy_q <= sat32(py_wide);
        cx_q <= cfg_i.julia_real;
        cy_q <= cfg_i.julia_imag;
      end
    end
    if (state_q == ST_MUL) begin
      pxx_q <= 64'(zx_q) * 64'(zx_q);
      pyy_q <= 64'(zy_q) * 64'(zy_q);
      pxy_q <= 64'(zx_q) * 64'(zy_q);
    end
    if (state_q == ST_ADD) begin
      esc_q <= mag > FOUR_Q54;
      if (!stop) begin
        zx_q    <= sat32(nx_wide);
        zy_q    <= sat32(ny_wide);
        count_q <= count_q + COUNT_W'(1);
      end
    end
    if (load_out) begin
      red_q     <= palette_on ? shade(Levels - digit[0]) : 8'd0;
      green_q   <= palette_on ? shade(Levels - digit[1]) : 8'd0;
      blue_q    <= palette_on ? shade(Levels - digit[2]) : 8'd0;
      iter_q    <= count_q;
      escaped_q <= esc_q;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign iterations_o = iter_q;
  assign escaped_o    = escaped_q;

endmodule

// File: hdl/escape_time_fractal_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Flow: an accepted word passes ST_MAP_MUL and ST_MAP_ADD, then the loop
// ST_MUL / ST_ADD of z = z*z + c until escape or the limit, then ST_DONE.
// Input: the next word is taken once the last result is loaded; it is taken
// while that result waits in the output register.
// Reset: asynchronous, active low; config registers return to default view.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel import efp_pkg::*; #(
  parameter int IMAGE_WIDTH    = DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT   = DEF_IMAGE_HEIGHT,
  parameter int PALETTE_LEVELS = DEF_PALETTE_LEVELS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_W-1:0]    pixel_column_i,
  input  logic [COORD_W-1:0]    pixel_row_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic [COUNT_W-1:0]    iterations_o,
  output logic                  escaped_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_origin        <= RST_X_ORIGIN;
      cfg_q.x_step          <= RST_X_STEP;
      cfg_q.y_origin        <= RST_Y_ORIGIN;
      cfg_q.y_step          <= RST_Y_STEP;
      cfg_q.mode_mandelbrot <= RST_MODE_MANDEL;
      cfg_q.julia_real      <= RST_JULIA_REAL;
      cfg_q.julia_imag      <= RST_JULIA_IMAG;
      cfg_q.iteration_limit <= RST_ITER_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_X_ORIGIN:   cfg_q.x_origin        <= $signed(cfg_data_i);
        CFG_X_STEP:     cfg_q.x_step          <= cfg_data_i[30:0];
        CFG_Y_ORIGIN:   cfg_q.y_origin        <= $signed(cfg_data_i);
        CFG_Y_STEP:     cfg_q.y_step          <= cfg_data_i[30:0];
        CFG_MODE:       cfg_q.mode_mandelbrot <= cfg_data_i[0];
        CFG_JULIA_REAL: cfg_q.julia_real      <= $signed(cfg_data_i);
        CFG_JULIA_IMAG: cfg_q.julia_imag      <= $signed(cfg_data_i);
        CFG_ITER_LIMIT: cfg_q.iteration_limit <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  efp_core #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .PALETTE_LEVELS(PALETTE_LEVELS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_column_i(pixel_column_i),
    .pixel_row_i   (pixel_row_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .iterations_o  (iterations_o),
    .escaped_o     (escaped_o)
  );

endmodule
